// File: rtl/isq_pkg.sv
// ----------------------------------------------------------------------------
// isq_pkg
// Shared types and codes for the I2C register access sequencer.
// ----------------------------------------------------------------------------
package isq_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_EVENT = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_START_TX  = 3'd1,
        OP_TX        = 3'd2,
        OP_RSTART_TX = 3'd3,
        OP_RX_NACK   = 3'd4,
        OP_STOP      = 3'd5
    } bus_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ARB  = 2'd1,
        ST_NACK = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_ADDR_W = 7'b0000010,
        PH_REG    = 7'b0000100,
        PH_DATA   = 7'b0001000,
        PH_ADDR_R = 7'b0010000,
        PH_RX     = 7'b0100000,
        PH_STOP   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       arb_lost;
        logic       got_nack;
        logic [7:0] rx_byte;
    } cmd_t;

    typedef struct packed {
        bus_op_t    bus_op;
        logic [7:0] tx_byte;
        logic       done_res;
        status_t    status;
        logic [7:0] read_data;
    } res_t;

endpackage

// File: rtl/isq_cmd_if.sv
// ----------------------------------------------------------------------------
// isq_cmd_if
// Input channel: requests and byte-done events.
// ----------------------------------------------------------------------------
interface isq_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       arb_lost;
    logic       got_nack;
    logic [7:0] rx_byte;

    modport source (
        output valid, mode, dev_addr, reg_addr, wr_data, arb_lost, got_nack, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, dev_addr, reg_addr, wr_data, arb_lost, got_nack, rx_byte,
        output ready
    );
endinterface

// File: rtl/isq_res_if.sv
// ----------------------------------------------------------------------------
// isq_res_if
// Output channel: bus operation and transfer status.
// ----------------------------------------------------------------------------
interface isq_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_op;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;

    modport source (
        output valid, bus_op, tx_byte, done_res, status, read_data,
        input  ready
    );
    modport sink (
        input  valid, bus_op, tx_byte, done_res, status, read_data,
        output ready
    );
endinterface

// File: rtl/i2c_register_access_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer
// Single-register I2C read/write sequencer above a byte-level controller.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the result register is full and not taken.
// Each item is captured in an input register; when it advances, the phase
// logic updates the state and loads the result register, so exactly one
// result is produced per item. ready drops only when the result register
// is full and not being taken.
module i2c_register_access_sequencer
    import isq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    isq_cmd_if.sink      cmd,
    isq_res_if.source    res
);

    logic       in_vld_reg;
    cmd_t       cmd_reg;
    logic       out_vld_reg;
    res_t       res_reg;
    res_t       res_next;

    phase_t     phase_reg,     phase_next;
    logic       is_read_reg,   is_read_next;
    logic [6:0] dev_addr_reg,  dev_addr_next;
    logic [7:0] reg_addr_reg,  reg_addr_next;
    logic [7:0] wr_data_reg,   wr_data_next;
    logic [7:0] rx_data_reg,   rx_data_next;

    logic       advance;
    logic       fault_phase;

    assign advance   = in_vld_reg && (!out_vld_reg || res.ready);
    assign cmd.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_IDLE;
            is_read_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_vld_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                phase_reg   <= phase_next;
                is_read_reg <= is_read_next;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            cmd_reg.mode     <= cmd.mode;
            cmd_reg.dev_addr <= cmd.dev_addr;
            cmd_reg.reg_addr <= cmd.reg_addr;
            cmd_reg.wr_data  <= cmd.wr_data;
            cmd_reg.arb_lost <= cmd.arb_lost;
            cmd_reg.got_nack <= cmd.got_nack;
            cmd_reg.rx_byte  <= cmd.rx_byte;
        end
        if (advance)
        begin
            res_reg      <= res_next;
            dev_addr_reg <= dev_addr_next;
            reg_addr_reg <= reg_addr_next;
            wr_data_reg  <= wr_data_next;
            rx_data_reg  <= rx_data_next;
        end
    end

    assign fault_phase = (phase_reg == PH_ADDR_W) || (phase_reg == PH_REG)
                      || (phase_reg == PH_DATA)   || (phase_reg == PH_ADDR_R);

    always_comb
    begin
        phase_next    = phase_reg;
        is_read_next  = is_read_reg;
        dev_addr_next = dev_addr_reg;
        reg_addr_next = reg_addr_reg;
        wr_data_next  = wr_data_reg;
        rx_data_next  = rx_data_reg;
        res_next      = '{bus_op: OP_NONE, tx_byte: 8'd0, done_res: 1'b0,
                          status: ST_OK, read_data: 8'd0};

        if (cmd_reg.mode inside {MODE_WRITE, MODE_READ})
        begin
            if (phase_reg == PH_IDLE)
            begin
                dev_addr_next    = cmd_reg.dev_addr;
                reg_addr_next    = cmd_reg.reg_addr;
                wr_data_next     = cmd_reg.wr_data;
                rx_data_next     = 8'd0;
                is_read_next     = (cmd_reg.mode == MODE_READ);
                phase_next       = PH_ADDR_W;
                res_next.bus_op  = OP_START_TX;
                res_next.tx_byte = {cmd_reg.dev_addr, 1'b0};
            end
        end
        else if (cmd_reg.mode == MODE_EVENT)
        begin
            if (fault_phase && (cmd_reg.arb_lost || cmd_reg.got_nack))
            begin
                res_next.done_res = 1'b1;
                res_next.status   = cmd_reg.arb_lost ? ST_ARB : ST_NACK;
                phase_next        = PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    PH_ADDR_W:
                    begin
                        res_next.bus_op  = OP_TX;
                        res_next.tx_byte = reg_addr_reg;
                        phase_next       = PH_REG;
                    end
                    PH_REG:
                    begin
                        if (is_read_reg)
                        begin
                            res_next.bus_op  = OP_RSTART_TX;
                            res_next.tx_byte = {dev_addr_reg, 1'b1};
                            phase_next       = PH_ADDR_R;
                        end
                        else
                        begin
                            res_next.bus_op  = OP_TX;
                            res_next.tx_byte = wr_data_reg;
                            phase_next       = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        res_next.bus_op = OP_STOP;
                        phase_next      = PH_STOP;
                    end
                    PH_ADDR_R:
                    begin
                        res_next.bus_op = OP_RX_NACK;
                        phase_next      = PH_RX;
                    end
                    PH_RX:
                    begin
                        rx_data_next    = cmd_reg.rx_byte;
                        res_next.bus_op = OP_STOP;
                        phase_next      = PH_STOP;
                    end
                    PH_STOP:
                    begin
                        res_next.done_res  = 1'b1;
                        res_next.read_data = is_read_reg ? rx_data_reg : 8'd0;
                        phase_next         = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign res.valid     = out_vld_reg;
    assign res.bus_op    = res_reg.bus_op;
    assign res.tx_byte   = res_reg.tx_byte;
    assign res.done_res  = res_reg.done_res;
    assign res.status    = res_reg.status;
    assign res.read_data = res_reg.read_data;

`ifndef SYNTHESIS
    a_done_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.done_res |-> res_reg.bus_op == OP_NONE
                                            && res_reg.tx_byte == 8'd0)
        else $error("done item carries a bus operation");

    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.status != ST_OK |-> res_reg.done_res)
        else $error("fault status without done");

    a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(cmd_reg))
        else $error("stalled item lost or changed");
`endif

endmodule
